>>> sv/wyh_pkg.sv
// wyh_pkg: shared constants and types for the wyhash stream block
// no dependencies
`default_nettype none
package wyh_pkg;

    localparam int WYH_WINDOW_WORDS = 8;
    localparam int WYH_LENGTH_BITS  = 64;

    localparam logic [63:0] WYH_SECRET0 = 64'ha0761d6478bd642f;
    localparam logic [63:0] WYH_SECRET1 = 64'he7037ed1a0b428db;
    localparam logic [63:0] WYH_SECRET2 = 64'h8ebc6af09c88c6e3;
    localparam logic [63:0] WYH_SECRET3 = 64'h589965cc75374cc3;

    localparam logic [5:0] WYH_BLOCK_BYTES = 6'd48;
    localparam logic [5:0] WYH_FOLD_BYTES  = 6'd16;
    localparam logic [3:0] WYH_WORD_BYTES  = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABSORB,
        ST_FIN_PREP,
        ST_FOLD,
        ST_FIN_AB,
        ST_FIN_LEN
    } wyh_state_t;

    typedef struct packed {
        logic        start;
        logic [63:0] x;
        logic [63:0] y;
    } wyh_mix_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } wyh_mix_rsp_t;

endpackage
`default_nettype wire

>>> sv/wyh_mix.sv
// wyh_mix: iterative 64x64 multiply, high half xor low half
// one 32x32 multiplier reused over four partial products; uses wyh_pkg
`default_nettype none
module wyh_mix
    import wyh_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire wyh_mix_req_t req,
    output wyh_mix_rsp_t      rsp
);

    logic [63:0]  x_reg, y_reg;
    logic [63:0]  pp_reg, pp_next;
    logic [127:0] acc_reg, acc_next;
    logic [2:0]   step_reg, step_next;
    logic         busy_reg, busy_next;
    logic [31:0]  mul_a, mul_b;
    logic [127:0] pp_shifted;

    // partial product order: lo*lo, lo*hi, hi*lo, hi*hi
    always_comb
    begin
        case (step_reg)
            3'd0:    begin mul_a = x_reg[31:0];  mul_b = y_reg[31:0];  end
            3'd1:    begin mul_a = x_reg[31:0];  mul_b = y_reg[63:32]; end
            3'd2:    begin mul_a = x_reg[63:32]; mul_b = y_reg[31:0];  end
            default: begin mul_a = x_reg[63:32]; mul_b = y_reg[63:32]; end
        endcase
    end

    // shift of the product registered in the previous step
    always_comb
    begin
        case (step_reg)
            3'd1:    pp_shifted = {64'd0, pp_reg};
            3'd2:    pp_shifted = {32'd0, pp_reg, 32'd0};
            3'd3:    pp_shifted = {32'd0, pp_reg, 32'd0};
            3'd4:    pp_shifted = {pp_reg, 64'd0};
            default: pp_shifted = '0;
        endcase
    end

    always_comb
    begin
        pp_next   = pp_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (req.start)
        begin
            acc_next  = '0;
            step_next = 3'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            pp_next  = {32'd0, mul_a} * {32'd0, mul_b};
            acc_next = acc_reg + pp_shifted;
            if (step_reg == 3'd5)
                busy_next = 1'b0;
            else
                step_next = step_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg <= req.x;
            y_reg <= req.y;
        end
        pp_reg  <= pp_next;
        acc_reg <= acc_next;
    end

    assign rsp.done   = busy_reg && (step_reg == 3'd5);
    assign rsp.result = acc_reg[127:64] ^ acc_reg[63:0];

endmodule
`default_nettype wire

>>> sv/wyhash_64_stream.sv
// wyhash_64_stream: streaming 64-bit wyhash over little-endian message words
// uses wyh_pkg and wyh_mix
//
//  channel  | signals                            | direction
//  ---------+------------------------------------+----------
//  input    | in_valid/in_ready, data_word,      | in
//           | byte_count, last                   |
//  output   | out_valid/out_ready, hash_value    | out
//
// a word that leaves at most 48 unabsorbed bytes is only shifted into the window
// a word that takes them past 48 bytes runs three mixes, one per 16-byte lane
// finishing runs one mix per 16-byte fold plus two more
// each mix uses the shared 32x32 multiplier (four partial products)
// reset is asynchronous; the byte window is not cleared
// a finished hash waits in its register; the next message is taken meanwhile
`default_nettype none
module wyhash_64_stream
    import wyh_pkg::*;
#(
    parameter int WINDOW_WORDS = WYH_WINDOW_WORDS,
    parameter int LENGTH_BITS  = WYH_LENGTH_BITS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] data_word,
    input  wire logic [3:0]  byte_count,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      hash_value
);

    localparam int WIN_BYTES = WINDOW_WORDS * 8;
    localparam int WIN_BITS  = WIN_BYTES * 8;
    localparam int POS_W     = $clog2(WIN_BYTES);

    // state
    wyh_state_t             state_reg, state_next;
    logic [WIN_BITS-1:0]    win_reg, win_next;
    logic [63:0]            main_seed_reg, main_seed_next;
    logic [63:0]            side_one_reg, side_one_next;
    logic [63:0]            side_two_reg, side_two_next;
    logic [LENGTH_BITS-1:0] length_reg, length_next;
    logic [5:0]             pending_reg, pending_next;
    logic                   wide_reg, wide_next;
    logic                   last_reg, last_next;
    logic                   short_reg, short_next;
    logic [1:0]             lane_reg, lane_next;
    logic                   issued_reg, issued_next;
    logic                   out_valid_reg, out_valid_next;
    logic [63:0]            hash_reg, hash_next;

    wyh_mix_req_t mix_req;
    wyh_mix_rsp_t mix_rsp;
    logic         mix_start;
    logic [63:0]  mix_x, mix_y;

    logic                  in_fire;
    logic [3:0]            n_bytes;
    logic [5:0]            pending_in;
    logic [WIN_BITS+63:0]  win_pad;
    logic [POS_W:0]        base_wide;
    logic [POS_W-1:0]      base;
    logic [POS_W-1:0]      lane_pos;
    logic [POS_W-1:0]      k_pos;
    logic [POS_W-1:0]      off_pos;
    logic [63:0]           rd_head, rd_head_off, rd_tail, rd_tail_off, rd_mid, rd_end;
    logic [63:0]           short_a, short_b;
    logic [63:0]           fin_a, fin_b;

    function automatic logic [63:0] load8(input logic [WIN_BITS+63:0] w,
                                          input logic [POS_W-1:0] pos);
        load8 = w[{pos, 3'b000} +: 64];
    endfunction

    assign in_fire    = in_valid && in_ready;
    assign n_bytes    = (byte_count > WYH_WORD_BYTES) ? WYH_WORD_BYTES : byte_count;
    assign pending_in = pending_reg + {2'd0, n_bytes};
    assign win_pad    = {64'd0, win_reg};

    // start of the unabsorbed bytes at the top of the window
    assign base_wide = (POS_W+1)'(WIN_BYTES) - (POS_W+1)'(pending_reg);
    assign base      = base_wide[POS_W-1:0];
    assign lane_pos  = base + POS_W'({lane_reg, 4'b0000});
    assign k_pos     = POS_W'(pending_reg);
    assign off_pos   = POS_W'({pending_reg[5:3], 2'b00});

    // window reads for the short read rules
    assign rd_head     = load8(win_pad, base);
    assign rd_head_off = load8(win_pad, base + off_pos);
    assign rd_tail     = load8(win_pad, base + k_pos - POS_W'(4));
    assign rd_tail_off = load8(win_pad, base + k_pos - POS_W'(4) - off_pos);
    assign rd_mid      = load8(win_pad, base + POS_W'(pending_reg[5:1]));
    assign rd_end      = load8(win_pad, base + k_pos - POS_W'(1));

    // short messages: 4-byte reads for 4..16 bytes, 3 single bytes below
    always_comb
    begin
        short_a = '0;
        short_b = '0;
        if (pending_reg >= 6'd4)
        begin
            short_a = {rd_head[31:0], rd_head_off[31:0]};
            short_b = {rd_tail[31:0], rd_tail_off[31:0]};
        end
        else if (pending_reg != 6'd0)
        begin
            short_a = {40'd0, rd_head[7:0], rd_mid[7:0], rd_end[7:0]};
        end
    end

    // long messages: always the final 16 bytes of the window
    assign fin_a = short_reg ? short_a : load8(win_pad, POS_W'(WIN_BYTES - 16));
    assign fin_b = short_reg ? short_b : load8(win_pad, POS_W'(WIN_BYTES - 8));

    assign mix_req = '{start: mix_start, x: mix_x, y: mix_y};

    // mix operands per state
    always_comb
    begin
        mix_x = '0;
        mix_y = '0;
        case (state_reg)
            ST_ABSORB:
            begin
                case (lane_reg)
                    2'd0:
                    begin
                        mix_x = load8(win_pad, lane_pos) ^ WYH_SECRET1;
                        mix_y = load8(win_pad, lane_pos + POS_W'(8)) ^ main_seed_reg;
                    end
                    2'd1:
                    begin
                        mix_x = load8(win_pad, lane_pos) ^ WYH_SECRET2;
                        mix_y = load8(win_pad, lane_pos + POS_W'(8)) ^ side_one_reg;
                    end
                    default:
                    begin
                        mix_x = load8(win_pad, lane_pos) ^ WYH_SECRET3;
                        mix_y = load8(win_pad, lane_pos + POS_W'(8)) ^ side_two_reg;
                    end
                endcase
            end
            ST_FOLD:
            begin
                mix_x = load8(win_pad, base) ^ WYH_SECRET1;
                mix_y = load8(win_pad, base + POS_W'(8)) ^ main_seed_reg;
            end
            ST_FIN_AB:
            begin
                mix_x = fin_a ^ WYH_SECRET1;
                mix_y = fin_b ^ main_seed_reg;
            end
            ST_FIN_LEN:
            begin
                mix_x = WYH_SECRET1 ^ 64'(length_reg);
                mix_y = main_seed_reg;
            end
            default:
            begin
                mix_x = '0;
                mix_y = '0;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        mix_start = 1'b0;
        case (state_reg)
            ST_ABSORB, ST_FOLD, ST_FIN_AB:
                mix_start = !issued_reg;
            ST_FIN_LEN:
                mix_start = !issued_reg && !out_valid_reg;
            default:
                mix_start = 1'b0;
        endcase
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (pending_in > WYH_BLOCK_BYTES)
                        state_next = ST_ABSORB;
                    else if (last)
                        state_next = ST_FIN_PREP;
                end
            end
            ST_ABSORB:
            begin
                if (mix_rsp.done && lane_reg == 2'd2)
                    state_next = last_reg ? ST_FIN_PREP : ST_IDLE;
            end
            ST_FIN_PREP:
            begin
                if ((!wide_reg && pending_reg <= WYH_FOLD_BYTES)
                    || pending_reg <= WYH_FOLD_BYTES)
                    state_next = ST_FIN_AB;
                else
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                if (mix_rsp.done && (pending_reg - WYH_FOLD_BYTES) <= WYH_FOLD_BYTES)
                    state_next = ST_FIN_AB;
            end
            ST_FIN_AB:
            begin
                if (mix_rsp.done)
                    state_next = ST_FIN_LEN;
            end
            ST_FIN_LEN:
            begin
                if (mix_rsp.done)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb
    begin
        win_next       = win_reg;
        main_seed_next = main_seed_reg;
        side_one_next  = side_one_reg;
        side_two_next  = side_two_reg;
        length_next    = length_reg;
        pending_next   = pending_reg;
        wide_next      = wide_reg;
        last_next      = last_reg;
        short_next     = short_reg;
        lane_next      = lane_reg;
        hash_next      = hash_reg;
        out_valid_next = out_valid_reg;
        issued_next    = issued_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (mix_rsp.done)
            issued_next = 1'b0;
        else if (mix_start)
            issued_next = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    // new bytes enter at the top, older ones move down
                    win_next     = WIN_BITS'({data_word, win_reg} >> {n_bytes, 3'b000});
                    pending_next = pending_in;
                    length_next  = length_reg + LENGTH_BITS'(n_bytes);
                    last_next    = last;
                    lane_next    = 2'd0;
                end
            end
            ST_ABSORB:
            begin
                if (mix_rsp.done)
                begin
                    case (lane_reg)
                        2'd0:    main_seed_next = mix_rsp.result;
                        2'd1:    side_one_next  = mix_rsp.result;
                        default: side_two_next  = mix_rsp.result;
                    endcase
                    if (lane_reg == 2'd2)
                    begin
                        pending_next = pending_reg - WYH_BLOCK_BYTES;
                        wide_next    = 1'b1;
                    end
                    else
                        lane_next = lane_reg + 2'd1;
                end
            end
            ST_FIN_PREP:
            begin
                short_next = !wide_reg && (pending_reg <= WYH_FOLD_BYTES);
                if (wide_reg)
                    main_seed_next = main_seed_reg ^ side_one_reg ^ side_two_reg;
            end
            ST_FOLD:
            begin
                if (mix_rsp.done)
                begin
                    main_seed_next = mix_rsp.result;
                    pending_next   = pending_reg - WYH_FOLD_BYTES;
                end
            end
            ST_FIN_AB:
            begin
                if (mix_rsp.done)
                    main_seed_next = mix_rsp.result;
            end
            ST_FIN_LEN:
            begin
                if (mix_rsp.done)
                begin
                    hash_next      = mix_rsp.result;
                    out_valid_next = 1'b1;
                    // back to the start of a message
                    main_seed_next = WYH_SECRET0;
                    side_one_next  = WYH_SECRET0;
                    side_two_next  = WYH_SECRET0;
                    length_next    = '0;
                    pending_next   = '0;
                    wide_next      = 1'b0;
                end
            end
            default:
            begin
                win_next = win_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            main_seed_reg <= WYH_SECRET0;
            side_one_reg  <= WYH_SECRET0;
            side_two_reg  <= WYH_SECRET0;
            length_reg    <= '0;
            pending_reg   <= '0;
            wide_reg      <= 1'b0;
            last_reg      <= 1'b0;
            short_reg     <= 1'b0;
            lane_reg      <= 2'd0;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            main_seed_reg <= main_seed_next;
            side_one_reg  <= side_one_next;
            side_two_reg  <= side_two_next;
            length_reg    <= length_next;
            pending_reg   <= pending_next;
            wide_reg      <= wide_next;
            last_reg      <= last_next;
            short_reg     <= short_next;
            lane_reg      <= lane_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        hash_reg <= hash_next;
    end

    wyh_mix u_mix (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mix_req),
        .rsp   (mix_rsp)
    );

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

    // between words no more than one 48-byte block stays unabsorbed
    a_idle_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> pending_reg <= WYH_BLOCK_BYTES)
        else $error("unabsorbed block left in window");

    // a mix result only comes back for a mix that was issued
    a_mix_issued: assert property (@(posedge clk) disable iff (!rst_n)
        mix_rsp.done |-> issued_reg)
        else $error("mix result without request");

    // a final word always leads into the finishing sequence
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last |=> state_reg != ST_IDLE)
        else $error("final word did not start finishing");

    // a new hash is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> hash_reg == $past(hash_reg))
        else $error("waiting hash overwritten");

endmodule
`default_nettype wire
